// ===== design/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Field widths, register indexes, filter type codes and the control bundle
// that travels from the pipeline into the reconstruction datapath.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int BYTE_W  = 8;
    localparam int BPP_W   = 4;
    localparam int ROWCFG_W = 14;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [BPP_W-1:0]    BPP_RESET = 4'd4;
    localparam logic [ROWCFG_W-1:0] ROW_RESET = 14'd4096;

    // Filter type codes.
    localparam logic [BYTE_W-1:0] FLT_NONE  = 8'd0;
    localparam logic [BYTE_W-1:0] FLT_SUB   = 8'd1;
    localparam logic [BYTE_W-1:0] FLT_UP    = 8'd2;
    localparam logic [BYTE_W-1:0] FLT_AVG   = 8'd3;
    localparam logic [BYTE_W-1:0] FLT_PAETH = 8'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] filter;
        logic              first_row;
        logic              left_ok;
        logic              last;
    } psu_ctrl_t;

endpackage

// ===== design/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs filtered PNG image bytes against the previous scanline, which
// is kept in an on-chip line memory.
//
//   Channel   Direction  Payload
//   s_*       in         tdata: data_byte; tuser: image_start
//   m_*       out        tdata: pixel_byte; tlast: row_end; tuser: filter_error
//   cfg_*     in         index 0 bytes_per_pixel, index 1 row_bytes
//
// One byte is accepted per cycle unless a stall holds the input; a data byte
// passes the reconstruction stage and the output register before it appears
// on m_tvalid; filter type bytes produce no output. The line memory is read
// when a byte is accepted and written back as it leaves reconstruction;
// consecutive data bytes within a row address different entries. A write of
// bytes_per_pixel stalls the input while the pixel slot is rebuilt as column
// modulo bytes_per_pixel, one bit per cycle. There is no clearing pass: the
// first row reads zero above. A stalled output keeps one result in the
// output register and one in the reconstruction stage.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] image_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] pixel_byte
    output logic                            m_tlast,   // [0] row_end
    output logic                            m_tuser,   // [0] filter_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psu_pkg::ROWCFG_W-1:0]    cfg_data
);

    import psu_pkg::*;

    localparam int CW   = $clog2(MAX_ROW_BYTES);
    localparam int RBW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int SW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int DCW  = $clog2(CW + 1);
    localparam int CMPW = (RBW > ROWCFG_W) ? RBW : ROWCFG_W;

    // Configuration.
    logic [BPP_W-1:0]    cfg_bpp_reg;
    logic [ROWCFG_W-1:0] cfg_row_reg;
    logic [BPP_W-1:0]    bpp_eff;
    logic [RBW-1:0]      rb_eff;
    logic                cfg_wr;
    logic                bpp_wr;

    // Row tracking.
    logic [CW-1:0] col_reg, col_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [BYTE_W-1:0] filter_reg, filter_next;
    logic expect_reg, expect_next;
    logic first_row_reg, first_row_next;

    // Slot rebuild after a bytes_per_pixel write.
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic [CW-1:0]  div_shift_reg, div_shift_next;
    logic [SW-1:0]  div_rem_reg, div_rem_next;
    logic [SW:0]    div_try;
    logic           div_busy;

    // Reconstruction stage.
    logic              s1_valid_reg, s1_valid_next;
    psu_ctrl_t         s1_ctrl_reg;
    logic [BYTE_W-1:0] s1_data_reg;
    logic [SW-1:0]     s1_slot_reg;
    logic [CW-1:0]     s1_col_reg;
    logic              s1_fire;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_err_reg;

    logic [BYTE_W-1:0] left_reg   [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] upleft_reg [MAX_PIXEL_BYTES];

    logic              in_acc, filt_acc, data_acc;
    logic [RBW-1:0]    col_inc;
    logic              row_last;
    logic              left_ok;
    logic [SW:0]       slot_inc;
    psu_ctrl_t         acc_ctrl;
    logic [BYTE_W-1:0] above_rd;
    logic [BYTE_W-1:0] pixel;
    logic [BYTE_W-1:0] above_used;
    logic              pix_err;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign bpp_wr    = cfg_wr && (cfg_index == CFG_BYTES_PER_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_bpp_reg <= BPP_RESET;
            cfg_row_reg <= ROW_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_PIXEL: cfg_bpp_reg <= cfg_data[BPP_W-1:0];
                CFG_ROW_BYTES:       cfg_row_reg <= cfg_data;
                default:             cfg_row_reg <= cfg_row_reg;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_bpp_reg == '0)
        begin
            bpp_eff = BPP_W'(1);
        end
        else if (cfg_bpp_reg > BPP_W'(MAX_PIXEL_BYTES))
        begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end
        else
        begin
            bpp_eff = cfg_bpp_reg;
        end

        if (cfg_row_reg == '0)
        begin
            rb_eff = RBW'(1);
        end
        else if (CMPW'(cfg_row_reg) > CMPW'(MAX_ROW_BYTES))
        begin
            rb_eff = RBW'(MAX_ROW_BYTES);
        end
        else
        begin
            rb_eff = RBW'(cfg_row_reg);
        end
    end

    // Handshake.
    assign div_busy = (div_cnt_reg != '0);
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !div_busy && (!s1_valid_reg || s1_fire);
    assign in_acc   = s_tvalid && s_tready;
    // A new image forces its first byte to be taken as a filter type.
    assign filt_acc = in_acc && (expect_reg || s_tuser);
    assign data_acc = in_acc && !(expect_reg || s_tuser);

    assign col_inc  = RBW'(col_reg) + RBW'(1);
    assign row_last = (col_inc >= rb_eff);
    assign left_ok  = (RBW'(col_reg) >= RBW'(bpp_eff));
    assign slot_inc = {1'b0, slot_reg} + (SW + 1)'(1);

    always_comb
    begin
        acc_ctrl.filter    = filter_reg;
        acc_ctrl.first_row = first_row_reg;
        acc_ctrl.left_ok   = left_ok;
        acc_ctrl.last      = row_last;
    end

    // Restoring remainder: one column bit per cycle, MSB first.
    always_comb
    begin
        div_try = {div_rem_reg, div_shift_reg[CW-1]};
        if (BPP_W'(div_try) >= bpp_eff)
        begin
            div_try = div_try - (SW + 1)'(bpp_eff);
        end
    end

    always_comb
    begin
        col_next       = col_reg;
        slot_next      = slot_reg;
        filter_next    = filter_reg;
        expect_next    = expect_reg;
        first_row_next = first_row_reg;
        div_cnt_next   = div_cnt_reg;
        div_shift_next = div_shift_reg;
        div_rem_next   = div_rem_reg;

        if (bpp_wr)
        begin
            div_cnt_next   = DCW'(CW);
            div_shift_next = col_reg;
            div_rem_next   = '0;
        end
        else if (div_busy)
        begin
            div_cnt_next   = div_cnt_reg - DCW'(1);
            div_shift_next = div_shift_reg << 1;
            div_rem_next   = div_try[SW-1:0];
            if (div_cnt_reg == DCW'(1))
            begin
                slot_next = div_try[SW-1:0];
            end
        end

        if (filt_acc)
        begin
            filter_next    = s_tdata;
            expect_next    = 1'b0;
            col_next       = '0;
            slot_next      = '0;
            first_row_next = s_tuser ? 1'b1 : first_row_reg;
        end
        else if (data_acc)
        begin
            if (row_last)
            begin
                col_next       = '0;
                slot_next      = '0;
                expect_next    = 1'b1;
                first_row_next = 1'b0;
            end
            else
            begin
                col_next = col_inc[CW-1:0];
                if (BPP_W'(slot_inc) >= bpp_eff)
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_inc[SW-1:0];
                end
            end
        end
    end

    assign s1_valid_next  = data_acc || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            slot_reg      <= '0;
            filter_reg    <= FLT_NONE;
            expect_reg    <= 1'b1;
            first_row_reg <= 1'b1;
            div_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            slot_reg      <= slot_next;
            filter_reg    <= filter_next;
            expect_reg    <= expect_next;
            first_row_reg <= first_row_next;
            div_cnt_reg   <= div_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_shift_reg <= div_shift_next;
        div_rem_reg   <= div_rem_next;
        if (data_acc)
        begin
            s1_ctrl_reg <= acc_ctrl;
            s1_data_reg <= s_tdata;
            s1_slot_reg <= slot_reg;
            s1_col_reg  <= col_reg;
        end
        if (s1_fire)
        begin
            out_data_reg <= pixel;
            out_last_reg <= s1_ctrl_reg.last;
            out_err_reg  <= pix_err;
        end
    end

    // Left and above-left history, indexed by pixel slot. Written as the
    // byte leaves reconstruction, so a neighbor one pixel back is current.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_reg[i]   <= '0;
                upleft_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            left_reg[s1_slot_reg]   <= pixel;
            upleft_reg[s1_slot_reg] <= above_used;
        end
    end

    // Previous scanline. Read at accept, written back from reconstruction.
    psu_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (pixel),
        .rd_en   (data_acc),
        .rd_addr (col_reg),
        .rd_data (above_rd)
    );

    psu_recon u_recon (
        .ctrl         (s1_ctrl_reg),
        .data_byte    (s1_data_reg),
        .left         (left_reg[s1_slot_reg]),
        .above        (above_rd),
        .upleft       (upleft_reg[s1_slot_reg]),
        .pixel_byte   (pixel),
        .above_used   (above_used),
        .filter_error (pix_err)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

`ifndef ASSERT_OFF
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !div_busy |-> (BPP_W'(slot_reg) < bpp_eff))
        else $error("pixel slot not below bytes_per_pixel");

    a_row_end_expects_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (data_acc && row_last) |=> (expect_reg && (col_reg == '0)))
        else $error("row end did not return to filter type byte");

    a_filter_byte_restarts_row: assert property (@(posedge clk) disable iff (!rst_n)
        filt_acc |=> ((col_reg == '0) && (slot_reg == '0) && !expect_reg))
        else $error("filter type byte did not restart the row");

    a_data_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        data_acc |=> s1_valid_reg)
        else $error("accepted data byte lost before reconstruction");
`endif

endmodule

// ===== design/psu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/psu_recon.sv =====
// ----------------------------------------------------------------------------
// PNG byte reconstruction datapath
// Applies the row's filter to one byte from its left, above and above-left
// neighbors, with out-of-image neighbors forced to zero.
// ----------------------------------------------------------------------------
module psu_recon (
    input  psu_pkg::psu_ctrl_t        ctrl,
    input  logic [psu_pkg::BYTE_W-1:0] data_byte,
    input  logic [psu_pkg::BYTE_W-1:0] left,
    input  logic [psu_pkg::BYTE_W-1:0] above,
    input  logic [psu_pkg::BYTE_W-1:0] upleft,
    output logic [psu_pkg::BYTE_W-1:0] pixel_byte,
    output logic [psu_pkg::BYTE_W-1:0] above_used,
    output logic                       filter_error
);

    import psu_pkg::*;

    logic [BYTE_W-1:0]   a, b, c;
    logic [BYTE_W:0]     avg_sum;
    logic signed [9:0]   dist_a, dist_b, dist_c;
    logic [9:0]          pa, pb, pc;
    logic [BYTE_W-1:0]   paeth_pred;

    always_comb
    begin
        a = ctrl.left_ok ? left : '0;
        c = ctrl.left_ok ? upleft : '0;
        b = ctrl.first_row ? '0 : above;

        avg_sum = {1'b0, a} + {1'b0, b};

        // With p = a + b - c: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
        dist_a = $signed({2'b00, b}) - $signed({2'b00, c});
        dist_b = $signed({2'b00, a}) - $signed({2'b00, c});
        dist_c = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = dist_a[9] ? 10'(-dist_a) : 10'(dist_a);
        pb = dist_b[9] ? 10'(-dist_b) : 10'(dist_b);
        pc = dist_c[9] ? 10'(-dist_c) : 10'(dist_c);

        if ((pa <= pb) && (pa <= pc))
        begin
            paeth_pred = a;
        end
        else if (pb <= pc)
        begin
            paeth_pred = b;
        end
        else
        begin
            paeth_pred = c;
        end

        filter_error = 1'b0;
        unique case (ctrl.filter)
            FLT_NONE:  pixel_byte = data_byte;
            FLT_SUB:   pixel_byte = data_byte + a;
            FLT_UP:    pixel_byte = data_byte + b;
            FLT_AVG:   pixel_byte = data_byte + avg_sum[BYTE_W:1];
            FLT_PAETH: pixel_byte = data_byte + paeth_pred;
            default:
            begin
                pixel_byte   = data_byte;
                filter_error = 1'b1;
            end
        endcase

        above_used = b;
    end

endmodule
